// ----- rtl/tsv_pkg.sv -----
`timescale 1ns / 1ps

package tsv_pkg;

   // configuration register indexes
   localparam logic [1:0] CSR_GEOM_TOL    = 2'd0;
   localparam logic [1:0] CSR_REL_SHIFT   = 2'd1;
   localparam logic [1:0] CSR_CLOSED_PATH = 2'd2;

   localparam logic [4:0] REL_SHIFT_RESET = 5'd20;

   // segment kinds and arc directions
   localparam logic [1:0] KIND_LINE = 2'd0;
   localparam logic [1:0] KIND_ARC  = 2'd1;
   localparam logic [1:0] DIR_CW    = 2'd1;

   // latched path status
   localparam logic [1:0] STAT_OK          = 2'd0;
   localparam logic [1:0] STAT_INVALID     = 2'd1;
   localparam logic [1:0] STAT_UNSUPPORTED = 2'd2;

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_LOAD = 7'b0000010,
      S_DIST = 7'b0000100,
      S_ROOT = 7'b0001000,
      S_CMP  = 7'b0010000,
      S_POST = 7'b0100000,
      S_OUT  = 7'b1000000
   } state_type;

   // which squared distance the shared unit works on
   typedef enum logic [2:0] {
      OP_CONT  = 3'd0,   // from vs current point
      OP_CHORD = 3'd1,   // from vs to
      OP_RAD0  = 3'd2,   // from vs center
      OP_RAD1  = 3'd3,   // to vs center
      OP_CLOSE = 3'd4    // to vs path start
   } op_type;

endpackage

// ----- rtl/toolpath_segment_validator.sv -----
`timescale 1ns / 1ps

// Channel | Direction | Handshake           | Payload
// req     | in        | req_valid/req_stall | seg_kind, from/to/center u,v, turn_dir, final_seg
// rsp     | out       | rsp_valid/rsp_stall | path_status, path_done
// csr     | in        | csr_valid/csr_ready | csr_index, csr_wdata
//
// One segment at a time; req_stall is high from the accepting edge until S_IDLE.
// A squared distance is formed one multiplier bit per cycle, a radius by a restoring root
// (two radicand bits per cycle). Lines check continuity and chord, arcs also both radii;
// closed paths add a closure check and a segment after a latched error skips all checks.
// Reset is synchronous and clears control and status registers, not the datapath.
// The result waits in an output register; rsp_stall holds S_OUT only for a second result.

module toolpath_segment_validator #(
   parameter int COORD_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_seg_kind,
   input  logic [31:0] req_from_u,
   input  logic [31:0] req_from_v,
   input  logic [31:0] req_to_u,
   input  logic [31:0] req_to_v,
   input  logic [31:0] req_center_u,
   input  logic [31:0] req_center_v,
   input  logic [1:0]  req_turn_dir,
   input  logic        req_final_seg,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_path_status,
   output logic        rsp_path_done,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int CW   = COORD_BITS;
   localparam int XW   = CW + 32;
   localparam int AW   = 2 * CW + 1;     // squared distance
   localparam int NW   = 2 * CW + 2;     // radicand, even width
   localparam int RW   = CW + 4;         // root remainder
   localparam int CNTW = $clog2(CW + 1);

   // state and registers
   tsv_pkg::state_type state_ff, state_in;
   tsv_pkg::op_type    op_ff, op_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic [1:0]  kind_ff, kind_in, dir_ff, dir_in;
   logic        fin_ff, fin_in;
   logic [CW-1:0] fu_ff, fu_in, fv_ff, fv_in, tu_ff, tu_in, tv_ff, tv_in;
   logic [CW-1:0] cu_ff, cu_in, cv_ff, cv_in;
   logic [CW-1:0] su_ff, su_in, sv_ff, sv_in, pu_ff, pu_in, pv_ff, pv_in;
   logic        at_first_ff, at_first_in;
   logic [1:0]  err_ff, err_in;
   logic [15:0] tol_ff, tol_in;
   logic [4:0]  shift_ff, shift_in;
   logic        closed_ff, closed_in;
   logic [31:0] tol_sq_ff;
   logic [CW-1:0] mul_u_ff, mul_u_in, mul_v_ff, mul_v_in;
   logic [AW-1:0] mcd_u_ff, mcd_u_in, mcd_v_ff, mcd_v_in, acc_ff, acc_in;
   logic [NW-1:0] rad_ff, rad_in;
   logic [RW-1:0] rem_ff, rem_in;
   logic [CW:0]   root_ff, root_in, r0_ff, r0_in;
   logic        rsp_valid_ff, rsp_valid_in, done_ff, done_in;
   logic [1:0]  status_ff, status_in;

   // combinational helpers
   logic        req_beat, rsp_beat, out_free;
   logic [XW-1:0] x_fu, x_fv, x_tu, x_tv, x_cu, x_cv;
   logic [CW-1:0] op_au, op_av, op_bu, op_bv, du, dv;
   logic [CW:0]   diff_u, diff_v;
   logic [AW-1:0] part_u, part_v;
   logic        tol_hit;
   logic [RW-1:0] rem_sh, trial;
   logic [CW:0]   big, thr, rdiff;

   assign req_beat  = req_valid & ~req_stall;
   assign rsp_beat  = rsp_valid_ff & ~rsp_stall;
   assign out_free  = ~rsp_valid_ff | ~rsp_stall;
   assign req_stall = (state_ff != tsv_pkg::S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_path_status = status_ff;
   assign rsp_path_done   = done_ff;

   // take the low COORD_BITS of each coordinate
   assign x_fu = XW'(req_from_u);
   assign x_fv = XW'(req_from_v);
   assign x_tu = XW'(req_to_u);
   assign x_tv = XW'(req_to_v);
   assign x_cu = XW'(req_center_u);
   assign x_cv = XW'(req_center_v);

   // operand pair for the distance unit
   always_comb begin
      case (op_ff)
         tsv_pkg::OP_CONT: begin
            op_au = fu_ff; op_av = fv_ff; op_bu = pu_ff; op_bv = pv_ff;
         end
         tsv_pkg::OP_CHORD: begin
            op_au = fu_ff; op_av = fv_ff; op_bu = tu_ff; op_bv = tv_ff;
         end
         tsv_pkg::OP_RAD0: begin
            op_au = fu_ff; op_av = fv_ff; op_bu = cu_ff; op_bv = cv_ff;
         end
         tsv_pkg::OP_RAD1: begin
            op_au = tu_ff; op_av = tv_ff; op_bu = cu_ff; op_bv = cv_ff;
         end
         default: begin
            op_au = tu_ff; op_av = tv_ff; op_bu = su_ff; op_bv = sv_ff;
         end
      endcase
   end

   // absolute differences of sign-extended coordinates
   assign diff_u = {op_au[CW-1], op_au} - {op_bu[CW-1], op_bu};
   assign diff_v = {op_av[CW-1], op_av} - {op_bv[CW-1], op_bv};
   assign du = diff_u[CW] ? CW'(-diff_u) : diff_u[CW-1:0];
   assign dv = diff_v[CW] ? CW'(-diff_v) : diff_v[CW-1:0];

   // one multiplier bit per lane per cycle
   assign part_u = mul_u_ff[0] ? mcd_u_ff : '0;
   assign part_v = mul_v_ff[0] ? mcd_v_ff : '0;
   assign tol_hit = (acc_in <= AW'(tol_sq_ff));

   // restoring square root step
   assign rem_sh = {rem_ff[RW-3:0], rad_ff[NW-1:NW-2]};
   assign trial  = RW'({root_ff, 2'b01});

   // radius agreement
   assign big   = (r0_ff > root_ff) ? ((r0_ff > CW'(tol_ff)) ? r0_ff : (CW+1)'(tol_ff))
                                    : ((root_ff > (CW+1)'(tol_ff)) ? root_ff
                                                                   : (CW+1)'(tol_ff));
   assign thr   = big >> shift_ff;
   assign rdiff = (r0_ff > root_ff) ? (r0_ff - root_ff) : (root_ff - r0_ff);

   always_comb begin
      state_in = state_ff;  op_in = op_ff;  cnt_in = cnt_ff;
      kind_in = kind_ff;  dir_in = dir_ff;  fin_in = fin_ff;
      fu_in = fu_ff;  fv_in = fv_ff;  tu_in = tu_ff;  tv_in = tv_ff;
      cu_in = cu_ff;  cv_in = cv_ff;
      su_in = su_ff;  sv_in = sv_ff;  pu_in = pu_ff;  pv_in = pv_ff;
      at_first_in = at_first_ff;  err_in = err_ff;
      tol_in = tol_ff;  shift_in = shift_ff;  closed_in = closed_ff;
      mul_u_in = mul_u_ff;  mul_v_in = mul_v_ff;
      mcd_u_in = mcd_u_ff;  mcd_v_in = mcd_v_ff;  acc_in = acc_ff;
      rad_in = rad_ff;  rem_in = rem_ff;  root_in = root_ff;  r0_in = r0_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_beat;
      status_in = status_ff;  done_in = done_ff;

      // configuration beats
      if (csr_valid && csr_ready) begin
         case (csr_index)
            tsv_pkg::CSR_GEOM_TOL:    tol_in    = csr_wdata;
            tsv_pkg::CSR_REL_SHIFT:   shift_in  = csr_wdata[4:0];
            tsv_pkg::CSR_CLOSED_PATH: closed_in = csr_wdata[0];
            default: ;
         endcase
      end

      case (state_ff)
         tsv_pkg::S_IDLE: begin
            if (req_beat) begin
               kind_in = req_seg_kind;  dir_in = req_turn_dir;  fin_in = req_final_seg;
               fu_in = x_fu[CW-1:0];  fv_in = x_fv[CW-1:0];
               tu_in = x_tu[CW-1:0];  tv_in = x_tv[CW-1:0];
               cu_in = x_cu[CW-1:0];  cv_in = x_cv[CW-1:0];
               if (at_first_ff) begin
                  su_in = x_fu[CW-1:0];  sv_in = x_fv[CW-1:0];
                  pu_in = x_fu[CW-1:0];  pv_in = x_fv[CW-1:0];
                  at_first_in = 1'b0;
               end
               op_in    = tsv_pkg::OP_CONT;
               // skip every check once an error is latched
               state_in = (err_ff == tsv_pkg::STAT_OK) ? tsv_pkg::S_LOAD : tsv_pkg::S_POST;
            end
         end
         tsv_pkg::S_LOAD: begin
            mul_u_in = du;  mul_v_in = dv;
            mcd_u_in = AW'(du);  mcd_v_in = AW'(dv);
            acc_in   = '0;  cnt_in = '0;
            state_in = tsv_pkg::S_DIST;
         end
         tsv_pkg::S_DIST: begin
            acc_in   = acc_ff + part_u + part_v;
            mul_u_in = mul_u_ff >> 1;  mul_v_in = mul_v_ff >> 1;
            mcd_u_in = mcd_u_ff << 1;  mcd_v_in = mcd_v_ff << 1;
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == CNTW'(CW - 1)) begin
               case (op_ff)
                  tsv_pkg::OP_CONT: begin
                     if (!tol_hit) begin
                        err_in = tsv_pkg::STAT_INVALID;  state_in = tsv_pkg::S_POST;
                     end else if (kind_ff == tsv_pkg::KIND_LINE ||
                                  kind_ff == tsv_pkg::KIND_ARC) begin
                        op_in = tsv_pkg::OP_CHORD;  state_in = tsv_pkg::S_LOAD;
                     end else begin
                        err_in = tsv_pkg::STAT_UNSUPPORTED;  state_in = tsv_pkg::S_POST;
                     end
                  end
                  tsv_pkg::OP_CHORD: begin
                     if (tol_hit) begin
                        err_in = tsv_pkg::STAT_INVALID;  state_in = tsv_pkg::S_POST;
                     end else if (kind_ff == tsv_pkg::KIND_LINE) begin
                        state_in = tsv_pkg::S_POST;
                     end else begin
                        op_in = tsv_pkg::OP_RAD0;  state_in = tsv_pkg::S_LOAD;
                     end
                  end
                  tsv_pkg::OP_RAD0, tsv_pkg::OP_RAD1: begin
                     if (tol_hit) begin
                        err_in = tsv_pkg::STAT_INVALID;  state_in = tsv_pkg::S_POST;
                     end else begin
                        rad_in = NW'(acc_in);  rem_in = '0;  root_in = '0;
                        cnt_in = '0;  state_in = tsv_pkg::S_ROOT;
                     end
                  end
                  default: begin
                     if (!tol_hit) err_in = tsv_pkg::STAT_INVALID;
                     state_in = tsv_pkg::S_OUT;
                  end
               endcase
            end
         end
         tsv_pkg::S_ROOT: begin
            rad_in = rad_ff << 2;
            cnt_in = cnt_ff + 1'b1;
            if (rem_sh >= trial) begin
               rem_in  = rem_sh - trial;
               root_in = {root_ff[CW-1:0], 1'b1};
            end else begin
               rem_in  = rem_sh;
               root_in = {root_ff[CW-1:0], 1'b0};
            end
            if (cnt_ff == CNTW'(CW)) begin
               if (op_ff == tsv_pkg::OP_RAD0) begin
                  r0_in = root_in;  op_in = tsv_pkg::OP_RAD1;
                  state_in = tsv_pkg::S_LOAD;
               end else begin
                  state_in = tsv_pkg::S_CMP;
               end
            end
         end
         tsv_pkg::S_CMP: begin
            if (rdiff > thr || dir_ff > tsv_pkg::DIR_CW) err_in = tsv_pkg::STAT_INVALID;
            state_in = tsv_pkg::S_POST;
         end
         tsv_pkg::S_POST: begin
            // the current point follows the segment end even after an error
            pu_in = tu_ff;  pv_in = tv_ff;
            if (fin_ff && closed_ff && err_ff == tsv_pkg::STAT_OK) begin
               op_in = tsv_pkg::OP_CLOSE;  state_in = tsv_pkg::S_LOAD;
            end else begin
               state_in = tsv_pkg::S_OUT;
            end
         end
         tsv_pkg::S_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;  status_in = err_ff;  done_in = fin_ff;
               if (fin_ff) begin
                  err_in = tsv_pkg::STAT_OK;  at_first_in = 1'b1;
               end
               state_in = tsv_pkg::S_IDLE;
            end
         end
         default: state_in = tsv_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tsv_pkg::S_IDLE;
         op_ff        <= tsv_pkg::OP_CONT;
         cnt_ff       <= '0;
         su_ff <= '0;  sv_ff <= '0;  pu_ff <= '0;  pv_ff <= '0;
         at_first_ff  <= 1'b1;
         err_ff       <= tsv_pkg::STAT_OK;
         tol_ff       <= '0;
         shift_ff     <= tsv_pkg::REL_SHIFT_RESET;
         closed_ff    <= 1'b0;
         tol_sq_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         status_ff    <= tsv_pkg::STAT_OK;
         done_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         cnt_ff       <= cnt_in;
         su_ff <= su_in;  sv_ff <= sv_in;  pu_ff <= pu_in;  pv_ff <= pv_in;
         at_first_ff  <= at_first_in;
         err_ff       <= err_in;
         tol_ff       <= tol_in;
         shift_ff     <= shift_in;
         closed_ff    <= closed_in;
         tol_sq_ff    <= tol_ff * tol_ff;
         rsp_valid_ff <= rsp_valid_in;
         status_ff    <= status_in;
         done_ff      <= done_in;
      end
   end

   // datapath, no reset
   always_ff @(posedge clock) begin
      kind_ff <= kind_in;  dir_ff <= dir_in;  fin_ff <= fin_in;
      fu_ff <= fu_in;  fv_ff <= fv_in;  tu_ff <= tu_in;  tv_ff <= tv_in;
      cu_ff <= cu_in;  cv_ff <= cv_in;
      mul_u_ff <= mul_u_in;  mul_v_ff <= mul_v_in;
      mcd_u_ff <= mcd_u_in;  mcd_v_ff <= mcd_v_in;  acc_ff <= acc_in;
      rad_ff <= rad_in;  rem_ff <= rem_in;  root_ff <= root_in;  r0_ff <= r0_in;
   end

   // a fresh path never carries an old error
   a_first_clean: assert property (@(posedge clock) disable iff (reset)
      at_first_ff |-> err_ff == tsv_pkg::STAT_OK)
      else $error("error latched at path start");

   // an accepted segment always starts the sequencer
   a_start: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> state_ff != tsv_pkg::S_IDLE)
      else $error("segment accepted without work");

   // the root unit only serves the two radii
   a_root_op: assert property (@(posedge clock) disable iff (reset)
      state_ff == tsv_pkg::S_ROOT |-> (op_ff == tsv_pkg::OP_RAD0 || op_ff == tsv_pkg::OP_RAD1))
      else $error("root unit on wrong operand");

   // status code three is never produced
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> status_ff != 2'd3)
      else $error("bad status code");

endmodule
